[src/bid_pkg.sv]
// ----------------------------------------------------------------------------
// bid_pkg: shared types and constants of the bytecode instruction decoder
// Beat structs, opcode constants, opcode classification functions.
// ----------------------------------------------------------------------------
package bid_pkg;

  localparam int OFFSET_BITS = 32;

  localparam logic [7:0] OP_BIPUSH       = 8'h10;
  localparam logic [7:0] OP_SIPUSH       = 8'h11;
  localparam logic [7:0] OP_IINC         = 8'h84;
  localparam logic [7:0] OP_TABLESWITCH  = 8'haa;
  localparam logic [7:0] OP_LOOKUPSWITCH = 8'hab;
  localparam logic [7:0] OP_INVOKEIFACE  = 8'hb9;
  localparam logic [7:0] OP_INVOKEDYN    = 8'hba;
  localparam logic [7:0] OP_WIDE         = 8'hc4;
  localparam logic [7:0] OP_MULTIANEW    = 8'hc5;
  localparam logic [7:0] OP_IFNULL       = 8'hc6;
  localparam logic [7:0] OP_IFNONNULL    = 8'hc7;

  localparam logic [1:0] KIND_INSTR = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_BAD_WIDE  = 3'd2;
  localparam logic [2:0] ERR_LOW_HIGH  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  // opcode classes
  localparam logic [2:0] CLS_WIDE    = 3'd5;
  localparam logic [2:0] CLS_SWITCH  = 3'd6;
  localparam logic [2:0] CLS_UNKNOWN = 3'd7;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] code_byte;
    logic       first_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  opcode;
    logic [31:0] start_offset;
    logic [31:0] instr_length;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic        is_wide;
    logic [31:0] entry_index;
    logic [2:0]  error_code;
    logic        end_of_code;
  } out_beat_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0]             code_byte;
    logic                   first_byte;
    logic                   final_byte;
    logic [OFFSET_BITS-1:0] offset;
    logic [2:0]             op_cls;
    logic                   wide_ok;
  } cls_beat_t;

  function automatic logic [2:0] op_class(input logic [7:0] op);
    logic [2:0] c;
    c = CLS_UNKNOWN;
    if (op <= 8'h0f || (op >= 8'h1a && op <= 8'h35) ||
        (op >= 8'h3b && op <= 8'h98 && op != OP_IINC) ||
        (op >= 8'hac && op <= 8'hb1) || op == 8'hbe || op == 8'hbf ||
        op == 8'hc2 || op == 8'hc3 || op == 8'hca)
      c = 3'd0;
    else if (op == OP_BIPUSH || op == 8'h12 || (op >= 8'h15 && op <= 8'h19) ||
             (op >= 8'h36 && op <= 8'h3a) || op == 8'hbc)
      c = 3'd1;
    else if (op == OP_SIPUSH || op == 8'h13 || op == 8'h14 || op == OP_IINC ||
             (op >= 8'h99 && op <= 8'ha8) || op == OP_IFNULL || op == OP_IFNONNULL ||
             (op >= 8'hb2 && op <= 8'hb8) || op == 8'hbb || op == 8'hbd ||
             op == 8'hc0 || op == 8'hc1)
      c = 3'd2;
    else if (op == OP_MULTIANEW)
      c = 3'd3;
    else if (op == OP_INVOKEIFACE || op == OP_INVOKEDYN || op == 8'hc8 || op == 8'hc9)
      c = 3'd4;
    else if (op == OP_WIDE)
      c = CLS_WIDE;
    else if (op == OP_TABLESWITCH || op == OP_LOOKUPSWITCH)
      c = CLS_SWITCH;
    return c;
  endfunction

  function automatic logic wide_target(input logic [7:0] op);
    return (op >= 8'h15 && op <= 8'h19) || (op >= 8'h36 && op <= 8'h3a);
  endfunction

endpackage

[src/bytecode_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// bytecode_instruction_decoder: streaming stack-machine code decoder
// Finds instruction boundaries in a byte stream and emits decoded results.
// ----------------------------------------------------------------------------
// One code byte is accepted per cycle; every byte passes the front classifier,
// a four-beat queue and the back parser; the byte is held in the queue and its
// result in the back parser's output register. The back parser retires one byte
// per cycle whenever its output register is free or being taken, giving a
// sustained rate of one byte per cycle; a stall on the result side fills the
// queue and then stalls input. Each byte yields at most one result beat.
module bytecode_instruction_decoder import bid_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic      push, q_full, pop, q_not_empty;
  cls_beat_t push_data, pop_data;

  bid_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .push, .push_data, .q_full
  );

  bid_queue u_queue (
    .clk, .rst_n, .push, .push_data, .full(q_full),
    .pop, .pop_data, .not_empty(q_not_empty)
  );

  bid_back u_back (
    .clk, .rst_n, .q_not_empty, .q_data(pop_data), .pop,
    .out_valid, .out_stall, .out_data
  );

endmodule

[src/bid_front.sv]
// ----------------------------------------------------------------------------
// bid_front: byte intake
// Tracks the code offset, classifies each byte as a possible opcode and
// pushes the classified beat into the queue.
// ----------------------------------------------------------------------------
module bid_front import bid_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      push,
  output cls_beat_t push_data,
  input  logic      q_full
);

  logic [OFFSET_BITS-1:0] offset_r, offset_nxt, cur_off;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign cur_off  = in_data.first_byte ? '0 : offset_r;

  // offset restarts after the final byte
  always_comb begin
    offset_nxt = offset_r;
    if (push) offset_nxt = in_data.final_byte ? '0 : cur_off + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) offset_r <= '0;
    else        offset_r <= offset_nxt;
  end

  always_comb begin
    push_data.code_byte  = in_data.code_byte;
    push_data.first_byte = in_data.first_byte;
    push_data.final_byte = in_data.final_byte;
    push_data.offset     = cur_off;
    push_data.op_cls     = op_class(in_data.code_byte);
    push_data.wide_ok    = wide_target(in_data.code_byte);
  end

endmodule

[src/bid_queue.sv]
// ----------------------------------------------------------------------------
// bid_queue: classified beat queue
// Small fifo between the front and the back so each stalls on its own.
// ----------------------------------------------------------------------------
module bid_queue import bid_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_beat_t push_data,
  output logic      full,
  input  logic      pop,
  output cls_beat_t pop_data,
  output logic      not_empty
);

  cls_beat_t           mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full      = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_data  = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");

endmodule

[src/bid_back.sv]
// ----------------------------------------------------------------------------
// bid_back: instruction parser
// Pops classified beats, walks operand, wide, pad, header and table phases
// and produces one result beat per finished instruction, entry or error.
// ----------------------------------------------------------------------------
module bid_back import bid_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  cls_beat_t q_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  typedef enum logic [5:0] {
    PH_OPCODE   = 6'b000001,
    PH_OPERANDS = 6'b000010,
    PH_WIDE     = 6'b000100,
    PH_PAD      = 6'b001000,
    PH_HEADER   = 6'b010000,
    PH_ENTRY    = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_w;
  logic [31:0] start_r, start_nxt, start_w;
  logic [7:0]  opc_r, opc_nxt, opc_w;
  logic [2:0]  left_r, left_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] held0_r, held0_nxt, held1_r, held1_nxt, held2_r, held2_nxt;
  logic [32:0] ents_r, ents_nxt;
  logic [31:0] ecnt_r, ecnt_nxt;
  logic        wide_r, wide_nxt, wide_w;
  logic        skip_r, skip_nxt, skip_w;
  logic [1:0]  widx_r, widx_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] slen_r, slen_nxt;
  logic        ov_r, ov_nxt;
  out_beat_t   od_r, od_nxt;

  logic        can_take, emit;
  logic [31:0] off32, seen, v, a, b, lo, hi;
  logic [32:0] ents_calc;
  logic [35:0] tbl_bytes;
  logic [36:0] tot;

  assign can_take  = !ov_r || !out_stall;
  assign pop       = q_not_empty && can_take;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign off32 = 32'(q_data.offset);
  assign v     = {shift_r[23:0], q_data.code_byte};

  always_comb begin
    // restart on first byte
    phase_w = q_data.first_byte ? PH_OPCODE : phase_r;
    skip_w  = q_data.first_byte ? 1'b0 : skip_r;
    wide_w  = q_data.first_byte ? 1'b0 : wide_r;
    start_w = start_r;
    opc_w   = opc_r;
    if (phase_w == PH_OPCODE) begin
      start_w = off32;
      opc_w   = q_data.code_byte;
      wide_w  = 1'b0;
    end else if (phase_w == PH_WIDE) begin
      opc_w   = q_data.code_byte;
      wide_w  = 1'b1;
    end
    seen = (off32 - start_w) + 32'd1;

    phase_nxt = phase_r;  start_nxt = start_r;  opc_nxt = opc_r;
    left_nxt = left_r;    shift_nxt = shift_r;
    held0_nxt = held0_r;  held1_nxt = held1_r;  held2_nxt = held2_r;
    ents_nxt = ents_r;    ecnt_nxt = ecnt_r;    wide_nxt = wide_r;
    skip_nxt = skip_r;    widx_nxt = widx_r;    key_nxt = key_r;
    slen_nxt = slen_r;
    emit = 1'b0;
    od_nxt = od_r;
    ov_nxt = ov_r && out_stall;
    a = '0;  b = '0;  lo = held1_r;  hi = held2_r;
    ents_calc = '0;  tbl_bytes = '0;  tot = '0;

    if (pop) begin
      phase_nxt = phase_w;  start_nxt = start_w;  opc_nxt = opc_w;
      wide_nxt = wide_w;    skip_nxt = skip_w;
      od_nxt = '0;
      od_nxt.opcode       = opc_w;
      od_nxt.start_offset = start_w;
      od_nxt.is_wide      = wide_w;
      if (q_data.first_byte) begin
        left_nxt = '0;
        shift_nxt = '0;
      end
      if (!skip_w) begin
        unique case (phase_w)
          PH_OPCODE: begin
            shift_nxt = '0;
            if (q_data.op_cls == CLS_UNKNOWN) begin
              emit = 1'b1;
              od_nxt.kind = KIND_ERROR; od_nxt.instr_length = seen;
              od_nxt.error_code = ERR_UNKNOWN; skip_nxt = 1'b1;
            end else if (q_data.op_cls == 3'd0) begin
              emit = 1'b1;
              od_nxt.instr_length = 32'd1;
            end else if (q_data.op_cls == CLS_WIDE) begin
              phase_nxt = PH_WIDE;
            end else if (q_data.op_cls == CLS_SWITCH) begin
              held0_nxt = '0; held1_nxt = '0; held2_nxt = '0;
              widx_nxt = '0;  left_nxt = 3'd4;
              phase_nxt = (off32[1:0] == 2'b11) ? PH_HEADER : PH_PAD;
            end else begin
              left_nxt = q_data.op_cls;
              phase_nxt = PH_OPERANDS;
            end
          end
          PH_OPERANDS: begin
            shift_nxt = v;
            left_nxt = left_r - 3'd1;
            if (left_r == 3'd1) begin
              phase_nxt = PH_OPCODE;
              emit = 1'b1;
              if (wide_w) begin
                if (opc_w == OP_IINC) begin
                  a = {16'd0, v[31:16]}; b = {{16{v[15]}}, v[15:0]};
                end else a = {16'd0, v[15:0]};
              end else if (opc_w == OP_BIPUSH) a = {{24{v[7]}}, v[7:0]};
              else if (opc_w == OP_SIPUSH || (opc_w >= 8'h99 && opc_w <= 8'ha8) ||
                       opc_w == OP_IFNULL || opc_w == OP_IFNONNULL)
                a = {{16{v[15]}}, v[15:0]};
              else if (opc_w == OP_IINC) begin
                a = {24'd0, v[15:8]}; b = {{24{v[7]}}, v[7:0]};
              end else if (opc_w == OP_INVOKEIFACE) begin
                a = {16'd0, v[31:16]}; b = {24'd0, v[15:8]};
              end else if (opc_w == OP_INVOKEDYN) a = {16'd0, v[31:16]};
              else if (opc_w == OP_MULTIANEW) begin
                a = {16'd0, v[23:8]}; b = {24'd0, v[7:0]};
              end else a = v;
              od_nxt.instr_length = seen;
              od_nxt.operand_a = a;
              od_nxt.operand_b = b;
            end
          end
          PH_WIDE: begin
            if (q_data.code_byte == OP_IINC) begin
              left_nxt = 3'd4; phase_nxt = PH_OPERANDS;
            end else if (q_data.wide_ok) begin
              left_nxt = 3'd2; phase_nxt = PH_OPERANDS;
            end else begin
              emit = 1'b1;
              od_nxt.kind = KIND_ERROR; od_nxt.instr_length = seen;
              od_nxt.error_code = ERR_BAD_WIDE; skip_nxt = 1'b1;
              phase_nxt = PH_OPCODE;
            end
          end
          PH_PAD: begin
            if (off32[1:0] == 2'b11) phase_nxt = PH_HEADER;
          end
          PH_HEADER: begin
            shift_nxt = v;
            left_nxt = left_r - 3'd1;
            if (left_r == 3'd1) begin
              shift_nxt = '0;
              left_nxt = 3'd4;
              widx_nxt = widx_r + 2'd1;
              case (widx_r)
                2'd0:    held0_nxt = v;
                2'd1:    held1_nxt = v;
                default: held2_nxt = v;
              endcase
              if (opc_w == OP_TABLESWITCH && widx_r == 2'd2) begin
                hi = v;
                if ((lo ^ 32'h8000_0000) > (hi ^ 32'h8000_0000)) begin
                  emit = 1'b1;
                  od_nxt.kind = KIND_ERROR; od_nxt.instr_length = seen;
                  od_nxt.error_code = ERR_LOW_HIGH; skip_nxt = 1'b1;
                  phase_nxt = PH_OPCODE;
                end else begin
                  ents_calc = {1'b0, hi - lo} + 33'd1;
                  tbl_bytes = {1'b0, ents_calc, 2'b00};
                  tot = {5'd0, seen} + {1'b0, tbl_bytes};
                  slen_nxt = (tot[36:32] != '0) ? 32'hFFFF_FFFF : tot[31:0];
                  ents_nxt = ents_calc; ecnt_nxt = '0; widx_nxt = '0;
                  phase_nxt = PH_ENTRY;
                  emit = 1'b1;
                  od_nxt.instr_length = slen_nxt;
                  od_nxt.operand_a = held0_r;
                  od_nxt.operand_b = lo;
                  od_nxt.operand_c = hi;
                end
              end else if (opc_w == OP_LOOKUPSWITCH && widx_r == 2'd1) begin
                ents_calc = {1'b0, v};
                tbl_bytes = {ents_calc, 3'b000};
                tot = {5'd0, seen} + {1'b0, tbl_bytes};
                slen_nxt = (tot[36:32] != '0) ? 32'hFFFF_FFFF : tot[31:0];
                ents_nxt = ents_calc; ecnt_nxt = '0; widx_nxt = '0;
                phase_nxt = (v == '0) ? PH_OPCODE : PH_ENTRY;
                emit = 1'b1;
                od_nxt.instr_length = slen_nxt;
                od_nxt.operand_a = held0_r;
                od_nxt.operand_b = v;
              end
            end
          end
          PH_ENTRY: begin
            shift_nxt = v;
            left_nxt = left_r - 3'd1;
            if (left_r == 3'd1) begin
              shift_nxt = '0;
              left_nxt = 3'd4;
              if (opc_w == OP_LOOKUPSWITCH && widx_r == 2'd0) begin
                key_nxt = v; widx_nxt = 2'd1;
              end else begin
                widx_nxt = '0;
                emit = 1'b1;
                od_nxt.kind = KIND_ENTRY;
                od_nxt.instr_length = slen_r;
                od_nxt.operand_a = held0_r;
                od_nxt.operand_b = (opc_w == OP_TABLESWITCH) ? held1_r + ecnt_r : key_r;
                od_nxt.operand_c = v;
                od_nxt.entry_index = ecnt_r;
                ecnt_nxt = ecnt_r + 32'd1;
                ents_nxt = ents_r - 33'd1;
                if (ents_r == 33'd1) phase_nxt = PH_OPCODE;
              end
            end
          end
          default: phase_nxt = PH_OPCODE;
        endcase
        // code ends mid-instruction
        if (q_data.final_byte && !skip_nxt && phase_nxt != PH_OPCODE) begin
          emit = 1'b1;
          od_nxt = '0;
          od_nxt.kind = KIND_ERROR;
          od_nxt.opcode = opc_w;
          od_nxt.start_offset = start_w;
          od_nxt.is_wide = wide_w;
          od_nxt.instr_length = seen;
          od_nxt.error_code = ERR_TRUNCATED;
          skip_nxt = 1'b1;
        end
      end
      od_nxt.end_of_code = q_data.final_byte;
      if (q_data.final_byte) begin
        phase_nxt = PH_OPCODE; skip_nxt = 1'b0; wide_nxt = 1'b0;
        left_nxt = '0; shift_nxt = '0;
      end
      ov_nxt = emit;
      if (!emit) od_nxt = od_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE;
      skip_r  <= 1'b0;
      wide_r  <= 1'b0;
      left_r  <= '0;
      widx_r  <= '0;
      ents_r  <= '0;
      ecnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      wide_r  <= wide_nxt;
      left_r  <= left_nxt;
      widx_r  <= widx_nxt;
      ents_r  <= ents_nxt;
      ecnt_r  <= ecnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    opc_r   <= opc_nxt;
    shift_r <= shift_nxt;
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    held2_r <= held2_nxt;
    key_r   <= key_nxt;
    slen_r  <= slen_nxt;
    od_r    <= od_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(od_r)) else $error("result lost under stall");
  a_entries: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ENTRY |-> ents_r != '0) else $error("entry phase with no entries");
  a_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER || phase_r == PH_ENTRY) |-> left_r != '0 && left_r <= 3'd4)
    else $error("field count out of range");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> ((od_r.kind == KIND_ERROR) == (od_r.error_code != ERR_NONE)))
    else $error("error kind and code disagree");

endmodule
